// ===== src/irt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval reservation table package
// Shared constants and types: request opcodes, status codes, the table
// entry layout and the default table depth.
// ----------------------------------------------------------------------------
package irt_pkg;

  // Default number of table entries.
  localparam int DEFAULT_ENTRIES = 16;

  // Field widths.
  localparam int TIME_W   = 16;
  localparam int STATUS_W = 3;

  // Request opcodes.
  localparam logic OP_BOOK   = 1'b0;
  localparam logic OP_CANCEL = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_BOOKED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CONFLICT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd5;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] stop;
  } entry_t;

endpackage

// ===== src/irt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval reservation table channels
// Valid/ready channel interfaces for requests and status results.
// ----------------------------------------------------------------------------

// Request channel: opcode and interval bounds.
interface irt_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [irt_pkg::TIME_W-1:0]  interval_start;
  logic [irt_pkg::TIME_W-1:0]  interval_end;

  modport source (output valid, output op, output interval_start,
                  output interval_end, input ready);
  modport sink   (input valid, input op, input interval_start,
                  input interval_end, output ready);
endinterface

// Result channel: one status per request.
interface irt_out_if;
  logic                          valid;
  logic                          ready;
  logic [irt_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

// ===== src/interval_reservation_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval reservation table core
// Holds up to ENTRIES disjoint half-open intervals and answers book and
// cancel requests with one status each.
// ----------------------------------------------------------------------------
// After reset the block sweeps its entry memory once, one entry per cycle,
// and accepts no request until that sweep is done. For each request one
// comparator walks the entry memory, which has separate write and read
// ports, one entry per cycle to test overlap or find the matching start;
// each entry comes back through the registered read port, and a result
// state then hands the status to the output register once it is free or taken.
// An overlap or a matching cancel ends the walk at that entry. A book request
// with start not below end skips the walk and goes straight to the result
// state. A new request is taken only once the previous status has moved to
// the output register, and is taken while that status still waits there.
module interval_reservation_table_core #(
  parameter int ENTRIES = irt_pkg::DEFAULT_ENTRIES
) (
  input  logic            clk,
  input  logic            rst_n,
  irt_in_if.sink          in_req,
  irt_out_if.source       out_rsp
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [IW-1:0]                   rd_idx_r, rd_idx_nxt;
  logic                            rd_busy_r, rd_busy_nxt;
  logic                            cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]                   cmp_idx_r, cmp_idx_nxt;
  logic                            free_found_r, free_found_nxt;
  logic [IW-1:0]                   free_slot_r, free_slot_nxt;
  logic                            op_r, op_nxt;
  logic [irt_pkg::TIME_W-1:0]      start_r, start_nxt;
  logic [irt_pkg::TIME_W-1:0]      end_r, end_nxt;
  logic [irt_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [irt_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;

  // Entry memory with one write and one registered read port.
  irt_pkg::entry_t                 mem_r [ENTRIES];
  irt_pkg::entry_t                 rd_data_r;
  logic                            rd_en;
  logic                            wr_en;
  logic [IW-1:0]                   wr_addr;
  irt_pkg::entry_t                 wr_data;

  logic                            in_xfer;
  logic                            overlap;
  logic                            start_hit;
  logic                            free_here;
  logic [IW-1:0]                   slot_sel;

  assign in_req.ready  = (state_r == S_IDLE);
  assign in_xfer       = in_req.valid && in_req.ready;
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.status = out_status_r;

  // Shared comparator against the entry read last cycle.
  assign overlap   = rd_data_r.valid && (start_r < rd_data_r.stop) &&
                     (end_r > rd_data_r.start);
  assign start_hit = rd_data_r.valid && (rd_data_r.start == start_r);
  assign free_here = !rd_data_r.valid;
  assign slot_sel  = free_found_r ? free_slot_r : cmp_idx_r;

  // Sequencer: clearing sweep, request capture, scan and result hand-off.
  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    rd_busy_nxt    = rd_busy_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    op_nxt         = op_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = rd_idx_r;
    wr_data        = '0;

    // The output register drains independently of the sequencer.
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (rd_idx_r == LAST) begin
          rd_idx_nxt = '0;
          state_nxt  = S_IDLE;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          op_nxt         = in_req.op;
          start_nxt      = in_req.interval_start;
          end_nxt        = in_req.interval_end;
          rd_idx_nxt     = '0;
          rd_busy_nxt    = 1'b1;
          free_found_nxt = 1'b0;
          if (in_req.op == irt_pkg::OP_BOOK &&
              in_req.interval_start >= in_req.interval_end) begin
            status_nxt = irt_pkg::ST_INVALID;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue the next read while entries remain.
        if (rd_busy_r) begin
          rd_en       = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r;
          if (rd_idx_r == LAST) begin
            rd_busy_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        // Check the entry that came back from memory.
        if (cmp_vld_r) begin
          if (op_r == irt_pkg::OP_CANCEL) begin
            if (start_hit) begin
              wr_en      = 1'b1;
              wr_addr    = cmp_idx_r;
              status_nxt = irt_pkg::ST_CANCELLED;
              state_nxt  = S_RESP;
            end else if (cmp_idx_r == LAST) begin
              status_nxt = irt_pkg::ST_NOTFOUND;
              state_nxt  = S_RESP;
            end
          end else begin
            if (overlap) begin
              status_nxt = irt_pkg::ST_CONFLICT;
              state_nxt  = S_RESP;
            end else begin
              if (free_here && !free_found_r) begin
                free_found_nxt = 1'b1;
                free_slot_nxt  = cmp_idx_r;
              end
              if (cmp_idx_r == LAST) begin
                state_nxt = S_RESP;
                if (free_found_r || free_here) begin
                  wr_en         = 1'b1;
                  wr_addr       = slot_sel;
                  wr_data.valid = 1'b1;
                  wr_data.start = start_r;
                  wr_data.stop  = end_r;
                  status_nxt    = irt_pkg::ST_BOOKED;
                end else begin
                  status_nxt = irt_pkg::ST_FULL;
                end
              end
            end
          end
        end
      end

      S_RESP: begin
        // Load the output register once it is free or being taken.
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      rd_idx_r     <= '0;
      rd_busy_r    <= 1'b0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_idx_r     <= rd_idx_nxt;
      rd_busy_r    <= rd_busy_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    free_slot_r  <= free_slot_nxt;
    op_r         <= op_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
  end

  // Entry memory write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Entry memory registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_idx_r];
    end
  end

  // A transfer always leads into the scan or straight to the result.
  a_xfer_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_SCAN || state_r == S_RESP))
    else $error("request transfer did not start a scan or result");

  // A table write during the scan ends the request.
  a_write_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == S_SCAN) |=> (state_r == S_RESP))
    else $error("table written without finishing the request");

  // A loaded result carries a defined status code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r <= irt_pkg::ST_NOTFOUND))
    else $error("result holds an undefined status code");

  // A booked status only follows a book request.
  a_booked_op: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && status_r == irt_pkg::ST_BOOKED) |-> (op_r == irt_pkg::OP_BOOK))
    else $error("booked status for a cancel request");

endmodule
